FILE: design/seven_segment_command_mux_driver_top_macros.svh
// Assertion macros shared by the checker of the seven-segment command mux driver.
`ifndef SEVEN_SEGMENT_COMMAND_MUX_DRIVER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_COMMAND_MUX_DRIVER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ssd_pkg.sv
// Package: shared types, constants and lookup tables of the seven-segment driver.
`default_nettype none
package ssd_pkg;

  localparam int unsigned DIGITS_DEF     = 8;
  localparam int unsigned SLOT_TICKS_DEF = 255;

  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_POINT = 8'h80;
  localparam logic [7:0] DELAY_RST = 8'd255;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Screen contents and blanking delay, handed from parser to scanner.
  typedef struct packed {
    logic [7:0][7:0] seg;
    logic [7:0]      delay;
  } ssd_disp_t;

  // Candidate latched word for a scan tick.
  typedef struct packed {
    logic [15:0] word;
    logic        load;
  } ssd_drive_t;

  localparam logic [7:0] LEVEL_CURVE [128] = '{
    8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,
    8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd10,
    8'd10,  8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd14,  8'd15,  8'd16,  8'd17,
    8'd18,  8'd20,  8'd21,  8'd22,  8'd24,  8'd26,  8'd27,  8'd28,  8'd30,  8'd31,
    8'd32,  8'd34,  8'd35,  8'd36,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd44,
    8'd45,  8'd46,  8'd48,  8'd49,  8'd50,  8'd52,  8'd54,  8'd56,  8'd58,  8'd59,
    8'd61,  8'd63,  8'd65,  8'd67,  8'd68,  8'd69,  8'd71,  8'd72,  8'd74,  8'd76,
    8'd78,  8'd80,  8'd82,  8'd85,  8'd88,  8'd90,  8'd92,  8'd95,  8'd98,  8'd100,
    8'd103, 8'd106, 8'd109, 8'd112, 8'd116, 8'd119, 8'd122, 8'd125, 8'd129, 8'd134,
    8'd138, 8'd142, 8'd147, 8'd151, 8'd153, 8'd156, 8'd160, 8'd163, 8'd165, 8'd170,
    8'd175, 8'd180, 8'd185, 8'd190, 8'd195, 8'd200, 8'd207, 8'd214, 8'd218, 8'd221,
    8'd225, 8'd228, 8'd232, 8'd234, 8'd241, 8'd248, 8'd254, 8'd255
  };

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    logic [7:0] g;
    unique case (nib)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h77;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h39;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h79;
      4'hF: g = 8'h71;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

FILE: design/ssd_if.sv
// Interfaces: command/tick input channel and drive result channel.
`default_nettype none
interface ssd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface ssd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  echo_byte;
  logic        echo_valid;
  logic [15:0] drive_word;
  logic        drive_load;

  modport source (output valid, output echo_byte, output echo_valid,
                  output drive_word, output drive_load, input ready);
  modport sink   (input valid, input echo_byte, input echo_valid,
                  input drive_word, input drive_load, output ready);
endinterface
`default_nettype wire

FILE: design/ssd_parse.sv
// Command parser: modes, entry frame, screen contents and blanking delay.
`default_nettype none
module ssd_parse (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_en,
  input  wire logic [7:0]        rx_byte,
  output ssd_pkg::ssd_disp_t     disp
);
  import ssd_pkg::*;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_ASCII  = 2'd1;
  localparam logic [1:0] MODE_BINARY = 2'd2;
  localparam logic [1:0] MODE_LEVEL  = 2'd3;

  localparam logic [3:0] FRAME_LEN = 4'd8;

  logic [1:0]      mode_r, mode_nxt;
  logic [3:0]      idx_r, idx_nxt;
  logic [7:0][7:0] buf_r, buf_nxt;
  logic [7:0][7:0] shown_r, shown_nxt;
  logic [7:0]      delay_r, delay_nxt;
  logic [7:0]      up;
  logic            push;
  logic [7:0]      push_val;
  logic [3:0]      idx_prev;

  assign disp.seg   = shown_r;
  assign disp.delay = delay_r;

  always_comb begin
    up = (rx_byte >= 8'h61 && rx_byte <= 8'h7A) ? (rx_byte - 8'h20) : rx_byte;
  end

  assign idx_prev = idx_r - 4'd1;

  always_comb begin
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    buf_nxt   = buf_r;
    shown_nxt = shown_r;
    delay_nxt = delay_r;
    push      = 1'b0;
    push_val  = 8'h00;
    if (byte_en) begin
      unique case (mode_r)
        MODE_IDLE: begin
          priority if (up == 8'h41) begin
            mode_nxt = MODE_ASCII;
            idx_nxt  = '0;
          end else if (up == 8'h42) begin
            mode_nxt = MODE_BINARY;
            idx_nxt  = '0;
          end else if (up == 8'h52) begin
            shown_nxt = '0;
          end else if (up == 8'h4C) begin
            mode_nxt = MODE_LEVEL;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_LEVEL: begin
          delay_nxt = LEVEL_CURVE[rx_byte[7:1]];
          mode_nxt  = MODE_IDLE;
        end
        MODE_ASCII: begin
          priority if (up >= 8'h30 && up <= 8'h39) begin
            push     = 1'b1;
            push_val = hex_glyph(up[3:0]);
          end else if (up >= 8'h41 && up <= 8'h46) begin
            push     = 1'b1;
            push_val = hex_glyph(up[3:0] + 4'd9);
          end else if (up == 8'h2D) begin
            push     = 1'b1;
            push_val = SEG_MINUS;
          end else if (up == 8'h2E) begin
            // Decimal point lands on the previous symbol, never advances.
            if (idx_r != 4'd0 && idx_r <= FRAME_LEN) begin
              buf_nxt[idx_prev[2:0]] = buf_r[idx_prev[2:0]] | SEG_POINT;
            end
          end else begin
            push     = 1'b1;
            push_val = 8'h00;
          end
        end
        MODE_BINARY: begin
          push     = 1'b1;
          push_val = rx_byte;
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase

      if (push) begin
        if (idx_r < FRAME_LEN) begin
          buf_nxt[idx_r[2:0]] = push_val;
          idx_nxt             = idx_r + 4'd1;
        end
        if (idx_nxt >= FRAME_LEN) begin
          shown_nxt = buf_nxt;
          mode_nxt  = MODE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      idx_r   <= '0;
      shown_r <= '0;
      delay_r <= DELAY_RST;
    end else begin
      mode_r  <= mode_nxt;
      idx_r   <= idx_nxt;
      shown_r <= shown_nxt;
      delay_r <= delay_nxt;
    end
  end

  // Entry frame holds no reset value; entries are written before use.
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule
`default_nettype wire

FILE: design/ssd_scan.sv
// Multiplex scanner: digit and tick counters, blanking, latched drive word.
`default_nettype none
module ssd_scan #(
  parameter int unsigned DIGITS     = ssd_pkg::DIGITS_DEF,
  parameter int unsigned SLOT_TICKS = ssd_pkg::SLOT_TICKS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               tick_en,
  input  wire ssd_pkg::ssd_disp_t disp,
  output logic [15:0]             cur_word,
  output ssd_pkg::ssd_drive_t     drive
);
  import ssd_pkg::*;

  logic [2:0]  digit_r, digit_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] word_r, word_nxt;
  logic [7:0]  seg;
  logic [7:0]  sel;
  logic [8:0]  count_inc;
  logic [3:0]  digit_inc;

  assign seg       = disp.seg[digit_r];
  assign sel       = 8'd1 << digit_r;
  assign count_inc = {1'b0, count_r} + 9'd1;
  assign digit_inc = {1'b0, digit_r} + 4'd1;
  assign cur_word  = word_r;

  always_comb begin
    drive.word = word_r;
    drive.load = 1'b0;
    if (count_r == 8'd0) begin
      drive.word = (seg == 8'h00) ? 16'h0000 : {sel, seg};
      drive.load = 1'b1;
    end
    if (count_r == disp.delay) begin
      drive.word = 16'h0000;
      drive.load = 1'b1;
    end
  end

  always_comb begin
    word_nxt  = word_r;
    count_nxt = count_r;
    digit_nxt = digit_r;
    if (tick_en) begin
      word_nxt = drive.word;
      if (count_inc >= 9'(SLOT_TICKS)) begin
        count_nxt = '0;
        digit_nxt = (digit_inc >= 4'(DIGITS)) ? 3'd0 : digit_inc[2:0];
      end else begin
        count_nxt = count_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
      count_r <= '0;
      word_r  <= '0;
    end else begin
      digit_r <= digit_nxt;
      count_r <= count_nxt;
      word_r  <= word_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/seven_segment_command_mux_driver_top.sv
// Top level of the seven-segment command mux driver: pipeline and channel glue.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+---------------------------------------------
//  in_ch    | in  | valid / ready       | op, rx_byte
//  out_ch   | out | valid / ready       | echo_byte, echo_valid, drive_word, drive_load
//
//  One transaction in, one out; a new one is taken every cycle unless out_ch stalls.
//  A transaction passes the input register, then the result register.
//  Parser and scanner state advance as a transaction moves into the result register.
//  Reset (rst_n low, synchronous) empties both stages and restores the screen state.
//  A stall on out_ch holds the result; in_ch keeps taking until the input stage fills.
`default_nettype none
module seven_segment_command_mux_driver_top #(
  parameter int unsigned DIGITS     = ssd_pkg::DIGITS_DEF,
  parameter int unsigned SLOT_TICKS = ssd_pkg::SLOT_TICKS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ssd_in_if.sink   in_ch,
  ssd_out_if.source out_ch
);
  import ssd_pkg::*;

  // Input stage.
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_op_r;
  logic [7:0] s1_byte_r;

  // Result stage.
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  echo_byte_r;
  logic        echo_valid_r;
  logic [15:0] drive_word_r;
  logic        drive_load_r;

  logic        out_free;
  logic        advance;
  logic        in_take;
  logic        byte_en;
  logic        tick_en;

  ssd_disp_t   disp;
  ssd_drive_t  drive;
  logic [15:0] cur_word;

  // The result register frees when empty or when its transaction is taken.
  assign out_free = !out_valid_r || out_ch.ready;
  // Move the input stage forward whenever the result register can take it.
  assign advance  = s1_valid_r && out_free;
  // Take a new transaction when the input stage is empty or draining now.
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign byte_en = advance && (s1_op_r == OP_BYTE);
  assign tick_en = advance && (s1_op_r == OP_TICK);

  ssd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .rx_byte (s1_byte_r),
    .disp    (disp)
  );

  ssd_scan #(
    .DIGITS     (DIGITS),
    .SLOT_TICKS (SLOT_TICKS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick_en  (tick_en),
    .disp     (disp),
    .cur_word (cur_word),
    .drive    (drive)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on acceptance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_ch.op;
      s1_byte_r <= in_ch.rx_byte;
    end
    if (advance) begin
      if (s1_op_r == OP_BYTE) begin
        // Echo the byte; the latched word is left as it stands.
        echo_byte_r  <= s1_byte_r;
        echo_valid_r <= 1'b1;
        drive_word_r <= cur_word;
        drive_load_r <= 1'b0;
      end else begin
        // Scan tick: report the word after this tick and whether it reloaded.
        echo_byte_r  <= 8'h00;
        echo_valid_r <= 1'b0;
        drive_word_r <= drive.word;
        drive_load_r <= drive.load;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.echo_byte  = echo_byte_r;
  assign out_ch.echo_valid = echo_valid_r;
  assign out_ch.drive_word = drive_word_r;
  assign out_ch.drive_load = drive_load_r;

endmodule
`default_nettype wire

FILE: design/ssd_checker.sv
// Port-level checker of the seven-segment command mux driver, bound to the top level.
`default_nettype none
`include "seven_segment_command_mux_driver_top_macros.svh"
module ssd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  echo_byte,
  input wire logic        echo_valid,
  input wire logic [15:0] drive_word,
  input wire logic        drive_load
);

  `SSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_word) && $stable(echo_byte) && $stable(echo_valid) && $stable(drive_load), "result changed while stalled")
  `SSD_ASSERT_NOW(a_echo_no_load, out_valid && echo_valid, !drive_load, "received byte reported a reload")
  `SSD_ASSERT_NOW(a_tick_no_echo, out_valid && !echo_valid, echo_byte == 8'h00, "scan tick carried an echo byte")
  `SSD_ASSERT_NOW(a_word_shape, out_valid, (drive_word == 16'h0000) || ($onehot(drive_word[15:8]) && (drive_word[7:0] != 8'h00)), "drive word is not blank or one digit with segments")

endmodule

bind seven_segment_command_mux_driver_top ssd_checker u_ssd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .echo_byte  (out_ch.echo_byte),
  .echo_valid (out_ch.echo_valid),
  .drive_word (out_ch.drive_word),
  .drive_load (out_ch.drive_load)
);
`default_nettype wire

FILE: tb/sv/tb_seven_segment_command_mux_driver_top.sv
// Self-checking testbench for the seven-segment command mux driver top level.
module tb_seven_segment_command_mux_driver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssd_pkg::*;

  // Scan geometry of the instance under test (default parameters).
  localparam int SCAN_DIGITS  = int'(DIGITS_DEF);
  localparam int SCAN_SLOT    = int'(SLOT_TICKS_DEF);
  // Input register plus result register.
  localparam int PIPE_LATENCY = 2;

  // Command letters, upper case; the lower case form sets CASE_BIT.
  localparam logic [7:0] CMD_ASCII  = "A";
  localparam logic [7:0] CMD_BINARY = "B";
  localparam logic [7:0] CMD_BLANK  = "R";
  localparam logic [7:0] CMD_LEVEL  = "L";
  localparam logic [7:0] CASE_BIT   = 8'h20;
  // Symbols with a meaning of their own in ASCII entry.
  localparam logic [7:0] SYM_MINUS  = "-";
  localparam logic [7:0] SYM_POINT  = ".";

  // Segment patterns HGFEDCBA for the hex digits 0..F.
  localparam logic [7:0] SEG_GLYPH [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  // Blanking delay per level step; the level byte is halved to index it.
  localparam logic [7:0] BRIGHT_DELAY [128] = '{
    8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,
    8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd4,   8'd4,
    8'd4,   8'd4,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,   8'd7,
    8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd10,  8'd10,  8'd10,
    8'd11,  8'd12,  8'd13,  8'd14,  8'd14,  8'd15,  8'd16,  8'd17,
    8'd18,  8'd20,  8'd21,  8'd22,  8'd24,  8'd26,  8'd27,  8'd28,
    8'd30,  8'd31,  8'd32,  8'd34,  8'd35,  8'd36,  8'd38,  8'd39,
    8'd40,  8'd41,  8'd42,  8'd44,  8'd45,  8'd46,  8'd48,  8'd49,
    8'd50,  8'd52,  8'd54,  8'd56,  8'd58,  8'd59,  8'd61,  8'd63,
    8'd65,  8'd67,  8'd68,  8'd69,  8'd71,  8'd72,  8'd74,  8'd76,
    8'd78,  8'd80,  8'd82,  8'd85,  8'd88,  8'd90,  8'd92,  8'd95,
    8'd98,  8'd100, 8'd103, 8'd106, 8'd109, 8'd112, 8'd116, 8'd119,
    8'd122, 8'd125, 8'd129, 8'd134, 8'd138, 8'd142, 8'd147, 8'd151,
    8'd153, 8'd156, 8'd160, 8'd163, 8'd165, 8'd170, 8'd175, 8'd180,
    8'd185, 8'd190, 8'd195, 8'd200, 8'd207, 8'd214, 8'd218, 8'd221,
    8'd225, 8'd228, 8'd232, 8'd234, 8'd241, 8'd248, 8'd254, 8'd255
  };

  typedef enum logic [1:0] {PM_IDLE, PM_ASCII, PM_BINARY, PM_LEVEL} parse_mode_e;

  // One result transaction as the checker sees it.
  typedef struct packed {
    logic [7:0]  echo_byte;
    logic        echo_valid;
    logic [15:0] drive_word;
    logic        drive_load;
  } drive_result_t;

  logic clk;
  logic rst_n;

  ssd_in_if  in_ch ();
  ssd_out_if out_ch ();

  seven_segment_command_mux_driver_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the parser and scanner state.
  parse_mode_e mode_q;
  logic [7:0]  entry_q [8];
  int          entry_idx;
  logic [7:0]  screen_q [8];
  logic [7:0]  delay_q;
  int          scan_digit_q;
  int          scan_count_q;
  logic [15:0] latched_q;

  // Results predicted for accepted transactions, oldest first.
  drive_result_t expected_drive [$];

  // Traffic shaping, set per phase.
  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_left;

  // Bookkeeping for the closing summary.
  int errors;
  int items_sent;
  int results_checked;
  int bytes_seen;
  int ticks_seen;
  int frames_shown;
  int blank_loads;
  int digit_steps;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_shadow();
    mode_q       = PM_IDLE;
    entry_idx    = 0;
    delay_q      = DELAY_RST;
    scan_digit_q = 0;
    scan_count_q = 0;
    latched_q    = 16'h0000;
    foreach (entry_q[i]) entry_q[i] = 8'h00;
    foreach (screen_q[i]) screen_q[i] = 8'h00;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] b);
    return (b >= "a" && b <= "z") ? (b & ~CASE_BIT) : b;
  endfunction

  // Append one symbol; a full frame goes to the screen and ends entry.
  function automatic void store_symbol(input logic [7:0] v);
    if (entry_idx < 8) begin
      entry_q[entry_idx] = v;
      entry_idx++;
    end
    if (entry_idx >= 8) begin
      screen_q = entry_q;
      mode_q   = PM_IDLE;
      frames_shown++;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [7:0] u;
    u = upcase(b);
    case (mode_q)
      PM_IDLE: begin
        if (u == CMD_ASCII) begin
          mode_q    = PM_ASCII;
          entry_idx = 0;
        end else if (u == CMD_BINARY) begin
          mode_q    = PM_BINARY;
          entry_idx = 0;
        end else if (u == CMD_BLANK) begin
          foreach (screen_q[i]) screen_q[i] = 8'h00;
        end else if (u == CMD_LEVEL) begin
          mode_q = PM_LEVEL;
        end
        // anything else is only echoed
      end
      PM_LEVEL: begin
        delay_q = BRIGHT_DELAY[b[7:1]];
        mode_q  = PM_IDLE;
      end
      PM_ASCII: begin
        if (u >= "0" && u <= "9") begin
          store_symbol(SEG_GLYPH[4'(u - "0")]);
        end else if (u >= "A" && u <= "F") begin
          store_symbol(SEG_GLYPH[4'(u - "A" + 8'd10)]);
        end else if (u == SYM_MINUS) begin
          store_symbol(SEG_MINUS);
        end else if (u == SYM_POINT) begin
          // decimal point lands on the previous symbol and never advances
          if (entry_idx > 0 && entry_idx <= 8) entry_q[entry_idx - 1] |= SEG_POINT;
        end else begin
          store_symbol(8'h00);
        end
      end
      default: store_symbol(b);
    endcase
  endfunction

  // Advance the multiplex scan by one tick; return whether the word reloads.
  function automatic logic scan_tick();
    logic       load;
    logic [7:0] seg;
    load = 1'b0;
    if (scan_count_q == 0) begin
      seg       = screen_q[scan_digit_q];
      latched_q = (seg == 8'h00) ? 16'h0000 : ((16'h0100 << scan_digit_q) | {8'h00, seg});
      load      = 1'b1;
    end
    if (scan_count_q == int'(delay_q)) begin
      latched_q = 16'h0000;
      load      = 1'b1;
      blank_loads++;
    end
    scan_count_q++;
    if (scan_count_q >= SCAN_SLOT) begin
      scan_count_q = 0;
      scan_digit_q = (scan_digit_q + 1 >= SCAN_DIGITS) ? 0 : scan_digit_q + 1;
      digit_steps++;
    end
    return load;
  endfunction

  function automatic drive_result_t predict_drive(input logic op, input logic [7:0] b);
    drive_result_t r;
    r = '0;
    if (op == OP_BYTE) begin
      parse_byte(b);
      r.echo_byte  = b;
      r.echo_valid = 1'b1;
      bytes_seen++;
    end else begin
      r.drive_load = scan_tick();
      ticks_seen++;
    end
    r.drive_word = latched_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers and checker
  // ---------------------------------------------------------------------------

  // Offer one transaction. Entered and left at a falling edge; valid stays high
  // on return so back-to-back items need no drop in between.
  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      // idle cycle: drop valid and scramble the payload
      in_ch.valid   <= 1'b0;
      in_ch.op      <= 1'($urandom_range(0, 1));
      in_ch.rx_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    expected_drive.push_back(predict_drive(op, b));
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] letter(input logic [7:0] c);
    return $urandom_range(0, 1) ? (c | CASE_BIT) : c;
  endfunction

  task automatic send_ticks(input int n);
    repeat (n) send_item(OP_TICK, 8'($urandom));
  endtask

  // Binary command plus eight raw bytes, each blank with odds of one in four, with
  // stray ticks in between.
  task automatic send_binary_frame();
    send_item(OP_BYTE, letter(CMD_BINARY));
    while (mode_q != PM_IDLE) begin
      if ($urandom_range(0, 99) < 15) send_item(OP_TICK, 8'($urandom));
      else if ($urandom_range(0, 3) == 0) send_item(OP_BYTE, 8'h00);
      else send_item(OP_BYTE, 8'($urandom));
    end
  endtask

  // ASCII command plus symbols until the frame completes: hex digits in
  // either case, minus, points and unknown bytes, with stray ticks.
  task automatic send_ascii_frame();
    int         pick;
    int         n;
    logic [7:0] sym;
    send_item(OP_BYTE, letter(CMD_ASCII));
    while (mode_q != PM_IDLE) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_item(OP_TICK, 8'($urandom));
      end else begin
        if (pick < 55) begin
          n = $urandom_range(0, 15);
          sym = (n < 10) ? ("0" + 8'(n)) : letter("A" + 8'(n - 10));
        end else if (pick < 65) begin
          sym = SYM_MINUS;
        end else if (pick < 80) begin
          sym = SYM_POINT;
        end else begin
          sym = 8'($urandom);
        end
        send_item(OP_BYTE, sym);
      end
    end
  endtask

  // Drop valid, wait for every predicted result, then let the pipe settle.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (expected_drive.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic void compare_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    end
  endfunction

  // Checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    drive_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (expected_drive.size() == 0) begin
        $display("%0t ns: unexpected result: expected none, actual echo 0x%0h/%0b word 0x%0h/%0b",
                 $time, out_ch.echo_byte, out_ch.echo_valid, out_ch.drive_word,
                 out_ch.drive_load);
        errors++;
      end else begin
        want = expected_drive.pop_front();
        compare_field("echo_byte", 16'(want.echo_byte), 16'(out_ch.echo_byte));
        compare_field("echo_valid", 16'(want.echo_valid), 16'(out_ch.echo_valid));
        compare_field("drive_word", want.drive_word, out_ch.drive_word);
        compare_field("drive_load", 16'(want.drive_load), 16'(out_ch.drive_load));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Echo of unknown bytes at both extremes and a lower case blank command.
  task automatic test_command_echo();
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, CMD_BLANK | CASE_BIT);
    drain_results();
  endtask

  // ASCII entry: a point with nothing before it, hex digits in both cases,
  // minus, a point after minus, an unknown symbol that blanks, and a point on it.
  task automatic test_ascii_entry();
    send_item(OP_BYTE, CMD_ASCII | CASE_BIT);
    send_item(OP_BYTE, SYM_POINT);
    send_item(OP_BYTE, "0");
    send_item(OP_BYTE, "f");
    send_item(OP_BYTE, SYM_MINUS);
    send_item(OP_BYTE, SYM_POINT);
    send_item(OP_BYTE, "E");
    send_item(OP_BYTE, "z");
    send_item(OP_BYTE, SYM_POINT);
    send_item(OP_BYTE, "7");
    send_item(OP_BYTE, "c");
    send_item(OP_BYTE, "9");
    drain_results();
  endtask

  // Binary entry with every bit of the byte set and cleared along the frame.
  task automatic test_binary_entry();
    send_item(OP_BYTE, CMD_BINARY);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, 8'h55);
    send_item(OP_BYTE, 8'hAA);
    send_item(OP_BYTE, 8'h7F);
    send_item(OP_BYTE, 8'hFE);
    drain_results();
  endtask

  // Zero delay blanks on the same tick the digit loads; full level never blanks.
  task automatic test_level_blanking();
    send_item(OP_BYTE, CMD_LEVEL);
    send_item(OP_BYTE, 8'h00);
    send_ticks(2);
    send_item(OP_BYTE, CMD_LEVEL | CASE_BIT);
    send_item(OP_BYTE, 8'hFF);
    send_ticks(1);
    drain_results();
  endtask

  // Run the tick counter through two slot wraps so the digit select steps.
  task automatic test_scan_wrap();
    send_binary_frame();
    send_item(OP_BYTE, letter(CMD_LEVEL));
    send_item(OP_BYTE, 8'($urandom));
    send_ticks(2 * SCAN_SLOT + 20);
    drain_results();
  endtask

  // Hold the result channel off for a long stretch while the sender keeps
  // offering, so the pipe fills and in_ch stalls.
  task automatic test_output_backpressure();
    hold_req = 48;
    send_ascii_frame();
    send_ticks(6);
    drain_results();
  endtask

  // Well-formed command sequences with random content, plus noise bytes.
  task automatic run_mixed_traffic(input int n_items, input int idle, input int stall);
    int stop_at;
    int pick;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_ticks($urandom_range(1, 40));
      end else if (pick < 55) begin
        send_ascii_frame();
      end else if (pick < 68) begin
        send_binary_frame();
      end else if (pick < 78) begin
        send_item(OP_BYTE, letter(CMD_LEVEL));
        send_item(OP_BYTE, 8'($urandom));
      end else if (pick < 84) begin
        send_item(OP_BYTE, letter(CMD_BLANK));
      end else begin
        // noise: may start a command that the following items complete
        send_item(OP_BYTE, 8'($urandom));
      end
    end
    drain_results();
  endtask

  initial begin
    errors          = 0;
    items_sent      = 0;
    results_checked = 0;
    bytes_seen      = 0;
    ticks_seen      = 0;
    frames_shown    = 0;
    blank_loads     = 0;
    digit_steps     = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_req        = 0;
    hold_left       = 0;
    clear_shadow();

    // Hold every input at a known value through reset.
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_BYTE;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_command_echo();
    test_ascii_entry();
    test_binary_entry();
    test_level_blanking();
    test_scan_wrap();
    test_output_backpressure();

    // Random traffic under each idling mix.
    run_mixed_traffic(170, 0, 0);
    run_mixed_traffic(170, 58, 0);
    run_mixed_traffic(170, 0, 58);
    run_mixed_traffic(170, 26, 26);

    if (expected_drive.size() != 0) begin
      $display("%0t ns: %0d predicted results never arrived", $time, expected_drive.size());
      errors++;
    end

    $display("Covered %0d command bytes and %0d scan ticks; %0d results checked.",
             bytes_seen, ticks_seen, results_checked);
    $display("Frames shown: %0d, blanking reloads: %0d, digit slot advances: %0d.",
             frames_shown, blank_loads, digit_steps);
    if (errors == 0) begin
      $display("tb_seven_segment_command_mux_driver_top passed");
    end else begin
      $display("tb_seven_segment_command_mux_driver_top failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb_seven_segment_command_mux_driver_top failed");
    $finish;
  end

endmodule

FILE: seven_segment_command_mux_driver_top.f
+incdir+design
design/ssd_pkg.sv
design/ssd_if.sv
design/ssd_parse.sv
design/ssd_scan.sv
design/seven_segment_command_mux_driver_top.sv
design/ssd_checker.sv
tb/sv/tb_seven_segment_command_mux_driver_top.sv
